// ===== rtl/scaled_glyph_render_to_oled_bytes_unit_macros.svh =====
// Assertion macros used by the glyph renderer back end.
`ifndef SCALED_GLYPH_RENDER_TO_OLED_BYTES_UNIT_MACROS_SVH
`define SCALED_GLYPH_RENDER_TO_OLED_BYTES_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge out of reset.
`define SGR_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SGR_ASSERT_ALWAYS(lbl, expr, msg)
`define SGR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/sgr_pkg.sv =====
// Package: shared types, constants and the font table of the glyph renderer.
package sgr_pkg;

    localparam int DISPLAY_HEIGHT_DEF = 32;

    localparam logic [7:0] CTRL_CMD  = 8'h00;
    localparam logic [7:0] CTRL_DATA = 8'h40;
    localparam logic [7:0] CMD_COLS  = 8'h21;
    localparam logic [7:0] CMD_PAGES = 8'h22;
    localparam logic [7:0] BLOCK_BYTE = 8'hFF;

    localparam logic [1:0] SCALE_DOUBLE = 2'd2;
    localparam logic [6:0] GLYPH_BLOCK  = 7'd0;

    // One classified item as it travels from front to back.
    typedef struct packed {
        logic [6:0] glyph;
        logic       dbl;
        logic [6:0] col;
        logic [7:0] end_col;
        logic [1:0] page;
    } sgr_desc_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic      valid;
        sgr_desc_t desc;
    } sgr_head_t;

    // 5x8 column font, column 0 in the top byte of each row.
    function automatic logic [7:0] font_byte(input logic [6:0] glyph, input logic [2:0] cidx);
        logic [39:0] r;
        logic [7:0]  b;
        case (glyph)
            7'd0:  r = 40'hFFFFFFFFFF;
            7'd1:  r = 40'h0000000000;
            7'd2:  r = 40'h000CBE0C00;
            7'd3:  r = 40'h0E06000E06;
            7'd4:  r = 40'h48FC48FC48;
            7'd5:  r = 40'h4856D42400;
            7'd6:  r = 40'hC62610C8C6;
            7'd7:  r = 40'h6C92AC40A0;
            7'd8:  r = 40'h000E060000;
            7'd9:  r = 40'h007C820000;
            7'd10: r = 40'h00827C0000;
            7'd11: r = 40'h107C387C10;
            7'd12: r = 40'h10107C1010;
            7'd13: r = 40'h00E0600000;
            7'd14: r = 40'h1010101010;
            7'd15: r = 40'h0060600000;
            7'd16: r = 40'h4020100804;
            7'd17: r = 40'h7CA2928A7C;
            7'd18: r = 40'h0084FE8000;
            7'd19: r = 40'hC4A292928C;
            7'd20: r = 40'h449292926C;
            7'd21: r = 40'h302824FE20;
            7'd22: r = 40'h5E92929262;
            7'd23: r = 40'h7894929260;
            7'd24: r = 40'h02E2120A06;
            7'd25: r = 40'h6C9292926C;
            7'd26: r = 40'h0C9292523C;
            7'd27: r = 40'h006C6C0000;
            7'd28: r = 40'h00EC6C0000;
            7'd29: r = 40'h1028448200;
            7'd30: r = 40'h4848484848;
            7'd31: r = 40'h0082442810;
            7'd32: r = 40'h0402B2120C;
            7'd33: r = 40'h7C82BAAA3C;
            7'd34: r = 40'hFC222222FC;
            7'd35: r = 40'hFE9292926C;
            7'd36: r = 40'h7C82828244;
            7'd37: r = 40'hFE8282827C;
            7'd38: r = 40'hFE92929282;
            7'd39: r = 40'hFE12121202;
            7'd40: r = 40'h7C829292F4;
            7'd41: r = 40'hFE101010FE;
            7'd42: r = 40'h0082FE8200;
            7'd43: r = 40'h608080807E;
            7'd44: r = 40'hFE10284482;
            7'd45: r = 40'hFE80808080;
            7'd46: r = 40'hFE040804FE;
            7'd47: r = 40'hFE040810FE;
            7'd48: r = 40'h7C8282827C;
            7'd49: r = 40'hFE1212120C;
            7'd50: r = 40'h7C82A242BC;
            7'd51: r = 40'hFE121232CC;
            7'd52: r = 40'h4C92929264;
            7'd53: r = 40'h0202FE0202;
            7'd54: r = 40'h7E8080807E;
            7'd55: r = 40'h3E4080403E;
            7'd56: r = 40'h7E8078807E;
            7'd57: r = 40'hC6281028C6;
            7'd58: r = 40'h0E10E0100E;
            7'd59: r = 40'hE2928A8600;
            7'd60: r = 40'h00FE828200;
            7'd61: r = 40'h0408102040;
            7'd62: r = 40'h008282FE00;
            7'd63: r = 40'h0804020408;
            7'd64: r = 40'h8080808080;
            7'd65: r = 40'h00060E0000;
            7'd66: r = 40'hC8A8A89800;
            7'd67: r = 40'h107C828200;
            7'd68: r = 40'h0000FF0000;
            7'd69: r = 40'h0082827C10;
            7'd70: r = 40'h0402040200;
            default: r = 40'h0000000000;
        endcase
        case (cidx)
            3'd0:    b = r[39:32];
            3'd1:    b = r[31:24];
            3'd2:    b = r[23:16];
            3'd3:    b = r[15:8];
            3'd4:    b = r[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Nibble bit i lands on byte bits 2i and 2i+1.
    function automatic logic [7:0] double_nibble(input logic [3:0] n);
        return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
    endfunction

endpackage

// ===== rtl/sgr_front.sv =====
// Front end: takes an item, folds the code and builds the draw descriptor.
module sgr_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [6:0]        character,
    input  logic [1:0]        scale,
    input  logic [6:0]        column,
    input  logic [4:0]        row,
    input  logic              queue_full,
    output logic              push,
    output sgr_pkg::sgr_desc_t desc
);

    logic [6:0] folded;
    logic       dbl;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign dbl      = (scale == sgr_pkg::SCALE_DOUBLE);

    always_comb
    begin
        // lowercase to uppercase, codes above 'z' down by 25
        if (character inside {[7'd97:7'd122]})
        begin
            folded = character - 7'd32;
        end
        else if (character > 7'd122)
        begin
            folded = character - 7'd25;
        end
        else
        begin
            folded = character;
        end

        if (folded inside {[7'd32:7'd101]})
        begin
            desc.glyph = folded - 7'd31;
        end
        else
        begin
            desc.glyph = sgr_pkg::GLYPH_BLOCK;
        end

        desc.dbl     = dbl;
        desc.col     = column;
        desc.end_col = {1'b0, column} + (dbl ? 8'd9 : 8'd4);
        desc.page    = row[4:3];
    end

endmodule

// ===== rtl/sgr_queue.sv =====
// Two-entry descriptor queue between front and back.
module sgr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sgr_pkg::sgr_desc_t push_desc,
    output logic               full,
    input  logic               pop,
    output sgr_pkg::sgr_head_t head
);

    sgr_pkg::sgr_desc_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.desc  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/sgr_back.sv =====
// Back end: byte sequencer and output register for the bus write stream.
`include "scaled_glyph_render_to_oled_bytes_unit_macros.svh"
module sgr_back #(
    parameter int DISPLAY_HEIGHT = sgr_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sgr_pkg::sgr_head_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         bus_byte,
    output logic               end_of_transfer,
    output logic               last
);

    localparam logic [2:0] LAST_PAGE  = 3'((DISPLAY_HEIGHT - 1) >> 3);
    localparam logic [5:0] STEP_DATA  = 6'd12;
    localparam logic [5:0] STEP_GLYPH = 6'd13;
    // command slots, two bytes each
    localparam logic [2:0] SLOT_COLS   = 3'd0;
    localparam logic [2:0] SLOT_X0     = 3'd1;
    localparam logic [2:0] SLOT_X1     = 3'd2;
    localparam logic [2:0] SLOT_PAGES  = 3'd3;
    localparam logic [2:0] SLOT_P0     = 3'd4;
    localparam logic [2:0] SLOT_P1     = 3'd5;

    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       eot_reg, eot_next;
    logic       last_reg, last_next;
    logic       load;
    logic [4:0] gofs;
    logic       half;
    logic [3:0] kofs;
    logic [7:0] fbyte;

    assign load            = head.valid && (!out_valid_reg || out_ready);
    assign pop             = load && last_next;
    assign out_valid       = out_valid_reg;
    assign bus_byte        = byte_reg;
    assign end_of_transfer = eot_reg;
    assign last            = last_reg;

    always_comb
    begin
        gofs  = 5'(step_reg - STEP_GLYPH);
        half  = head.desc.dbl && (gofs >= 5'd10);
        kofs  = half ? 4'(gofs - 5'd10) : gofs[3:0];
        fbyte = sgr_pkg::font_byte(head.desc.glyph,
                                   head.desc.dbl ? kofs[3:1] : gofs[2:0]);
        last_next = 1'b0;
        if (step_reg < STEP_DATA)
        begin
            if (!step_reg[0])
            begin
                byte_next = sgr_pkg::CTRL_CMD;
                eot_next  = 1'b0;
            end
            else
            begin
                eot_next = 1'b1;
                case (step_reg[3:1])
                    SLOT_COLS:  byte_next = sgr_pkg::CMD_COLS;
                    SLOT_X0:    byte_next = {1'b0, head.desc.col};
                    SLOT_X1:    byte_next = head.desc.end_col;
                    SLOT_PAGES: byte_next = sgr_pkg::CMD_PAGES;
                    SLOT_P0:    byte_next = {6'd0, head.desc.page};
                    SLOT_P1:    byte_next = {5'd0, LAST_PAGE};
                    default:    byte_next = sgr_pkg::CTRL_CMD;
                endcase
            end
        end
        else if (step_reg == STEP_DATA)
        begin
            byte_next = sgr_pkg::CTRL_DATA;
            eot_next  = 1'b0;
        end
        else
        begin
            if (head.desc.dbl)
            begin
                byte_next = half ? sgr_pkg::double_nibble(fbyte[7:4])
                                 : sgr_pkg::double_nibble(fbyte[3:0]);
                last_next = (gofs == 5'd19);
            end
            else
            begin
                byte_next = fbyte;
                last_next = (gofs == 5'd4);
            end
            eot_next = last_next;
        end

        step_next = step_reg;
        if (load)
        begin
            step_next = last_next ? 6'd0 : step_reg + 6'd1;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            eot_reg  <= eot_next;
            last_reg <= last_next;
        end
    end

    `SGR_ASSERT_ALWAYS(a_mid_item_head, (step_reg == 6'd0) || head.valid, "head lost mid item")
    `SGR_ASSERT_ALWAYS(a_last_is_eot, !(out_valid_reg && last_reg) || eot_reg, "last without eot")
    `SGR_ASSERT_NEXT(a_restart, load && last_next, step_reg == 6'd0, "step not cleared after last")

endmodule

// ===== rtl/scaled_glyph_render_to_oled_bytes_unit.sv =====
// Top level of the scaled glyph renderer: front end, descriptor queue, back end.
// With the back end idle, an accepted item passes through the queue registers, then the back-end output register.
// Each item is 18 bus bytes, or 33 at scale 2; the back-end sequencer emits one byte
// per cycle from the queue head while out_ready does not hold the output.
// Input accepts continue while the two-entry queue has room.
// Reset (rst_n low, asynchronous): queue empty, sequencer at step 0, no output valid.
module scaled_glyph_render_to_oled_bytes_unit #(
    parameter int DISPLAY_HEIGHT = sgr_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [6:0] character,
    input  logic [1:0] scale,
    input  logic [6:0] column,
    input  logic [4:0] row,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] bus_byte,
    output logic       end_of_transfer,
    output logic       last
);

    sgr_pkg::sgr_desc_t desc;
    sgr_pkg::sgr_head_t head;
    logic               push;
    logic               queue_full;
    logic               pop;

    // Front: classify the item (fold the code, pick the glyph, end column, page).
    sgr_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .scale      (scale),
        .column     (column),
        .row        (row),
        .queue_full (queue_full),
        .push       (push),
        .desc       (desc)
    );

    // Queue: lets the front keep taking items while the back is busy.
    sgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (desc),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    // Back: six command writes, then the data write with the glyph bytes.
    sgr_back #(
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bus_byte        (bus_byte),
        .end_of_transfer (end_of_transfer),
        .last            (last)
    );

endmodule
